>>> design/ddo_pkg.sv
// Shared constants, register indexes and helper functions for the odometry block.
package ddo_pkg;

  // Default parameter values.
  localparam int unsigned COUNT_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Configuration port shape.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd6;

  // Register reset values.
  localparam logic [15:0] COUNT_BASE_RST    = 16'd32768;
  localparam logic [23:0] DISTANCE_GAIN_RST = 24'd38600;
  localparam logic [23:0] HEADING_GAIN_RST  = 24'd4194304;
  localparam logic [15:0] UPDATE_RATE_RST   = 16'd1000;
  localparam logic [31:0] START_X_RST       = 32'd294912;
  localparam logic [31:0] START_Y_RST       = 32'd294912;
  localparam logic [31:0] START_HEADING_RST = 32'h4000_0000;

  // CORDIC gain compensation, Q0.30.
  localparam int unsigned  CORDIC_K_W = 30;
  localparam logic [29:0]  CORDIC_K   = 30'h26DD3B6A;

  // Datapath widths of the rotation stage.
  localparam int unsigned CLAMP_W = 34;
  localparam int unsigned ROT_W   = 36;
  localparam int unsigned ANG_W   = 34;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp a wide signed value to [-2^32, 2^32].
  function automatic logic signed [CLAMP_W-1:0] clamp34(input logic signed [63:0] v);
    logic signed [CLAMP_W-1:0] r;
    if (v > 64'sh1_0000_0000) begin
      r = 34'sh1_0000_0000;
    end else if (v < -64'sh1_0000_0000) begin
      r = -34'sh1_0000_0000;
    end else begin
      r = v[CLAMP_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/ddo_in_if.sv
// Input and output channel interfaces of the odometry block.
interface ddo_in_if import ddo_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COUNT_BITS-1:0] right_count;
  logic [COUNT_BITS-1:0] left_count;

  modport source (output valid, action, right_count, left_count, input ready);
  modport sink   (input valid, action, right_count, left_count, output ready);
endinterface

interface ddo_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] heading;
  logic [31:0] speed;
  logic [31:0] turn_rate;

  modport source (output valid, pos_x, pos_y, heading, speed, turn_rate, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, speed, turn_rate, output ready);
endinterface

>>> design/ddo_sermul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module ddo_sermul #(
  parameter int unsigned WA = 18,
  parameter int unsigned WB = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [WA-1:0]      a_i,
  input  logic        [WB-1:0]      b_i,
  output logic                      done_o,
  output logic signed [WA+WB-1:0]   p_o
);

  localparam int unsigned CW = $clog2(WB + 1);

  logic                    busy_q, done_q;
  logic [CW-1:0]           cnt_q;
  logic signed [WA+WB-1:0] a_q, acc_q;
  logic [WB-1:0]           b_q;

  // Control: count one multiplier bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the current bit is set.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= (WA+WB)'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> design/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CLAMP_W-1:0] x0_i,
  input  logic signed [31:0]       z0_i,
  output logic                     done_o,
  output logic signed [ROT_W-1:0]  x_o,
  output logic signed [ROT_W-1:0]  y_o
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS);

  logic                    busy_q, done_q;
  logic [IW-1:0]           i_q;
  logic signed [ROT_W-1:0] x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0] z_q, at;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed(ANG_W'(atan_lut(5'(i_q))));

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == IW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Micro-rotation toward zero residual angle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= ROT_W'(x0_i);
      y_q <= '0;
      z_q <= ANG_W'(z0_i);
    end else if (busy_q) begin
      if (!z_q[ANG_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

>>> design/differential_drive_odometry.sv
// Integrate action: the serial gain multipliers, the gain-compensation multiply
// and the CORDIC (one step per cycle) run in sequence; one tick is worked at a time.
// Restart action: the start pose is loaded and the sequencer goes straight to the output
// state. A new item is taken while a result waits in the output register. Reset loads
// default registers and start pose.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ddo_in_if.sink                in_i,
  ddo_out_if.source             out_o
);

  localparam int unsigned WD = COUNT_BITS + 2;
  localparam int unsigned WP = WD + 24;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [15:0] count_base_q, update_rate_q;
  logic [23:0] distance_gain_q, heading_gain_q;
  logic [31:0] start_x_q, start_y_q, start_heading_q;
  logic [31:0] pose_x_q, pose_y_q, pose_h_q;
  logic [2:0]  state_q;
  logic        ov_q, zero_rates_q;
  logic [31:0] mid_q, dfi_lo_q, speed_q, turn_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_base_q    <= COUNT_BASE_RST;
      distance_gain_q <= DISTANCE_GAIN_RST;
      heading_gain_q  <= HEADING_GAIN_RST;
      update_rate_q   <= UPDATE_RATE_RST;
      start_x_q       <= START_X_RST;
      start_y_q       <= START_Y_RST;
      start_heading_q <= START_HEADING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COUNT_BASE:    count_base_q    <= cfg_data_i[15:0];
        REG_DISTANCE_GAIN: distance_gain_q <= cfg_data_i[23:0];
        REG_HEADING_GAIN:  heading_gain_q  <= cfg_data_i[23:0];
        REG_UPDATE_RATE:   update_rate_q   <= cfg_data_i[15:0];
        REG_START_X:       start_x_q       <= cfg_data_i;
        REG_START_Y:       start_y_q       <= cfg_data_i;
        REG_START_HEADING: start_heading_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Wheel deltas and their sum and difference.
  logic                  in_acc;
  logic [COUNT_BITS-1:0] base;
  logic signed [COUNT_BITS:0] dr, dl;
  logic signed [WD-1:0]  sum_w, diff_w;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign base   = COUNT_BITS'(count_base_q);
  assign dr     = $signed({1'b0, in_i.right_count}) - $signed({1'b0, base});
  assign dl     = $signed({1'b0, in_i.left_count}) - $signed({1'b0, base});
  assign sum_w  = WD'(dr) + WD'(dl);
  assign diff_w = WD'(dl) - WD'(dr);

  // First multiply pass: distance and heading increments.
  logic                m1_start, ds_done, fi_done;
  logic signed [WP-1:0] p_ds, p_fi;

  assign m1_start = in_acc && !in_i.action;

  ddo_sermul #(.WA(WD), .WB(24)) u_mul_ds (
    .clk_i, .rst_ni, .start_i(m1_start), .a_i(sum_w), .b_i(distance_gain_q),
    .done_o(ds_done), .p_o(p_ds)
  );

  ddo_sermul #(.WA(WD), .WB(24)) u_mul_fi (
    .clk_i, .rst_ni, .start_i(m1_start), .a_i(diff_w), .b_i(heading_gain_q),
    .done_o(fi_done), .p_o(p_fi)
  );

  // Scale, clamp and midpoint heading.
  logic                      m2_start;
  logic signed [63:0]        dfi_full, half_full;
  logic signed [CLAMP_W-1:0] ds_cl, dfi_cl;

  assign m2_start  = (state_q == S_MUL1) && ds_done;
  assign dfi_full  = 64'(p_fi >>> 8);
  assign half_full = 64'(p_fi >>> 9);
  assign ds_cl     = clamp34(64'(p_ds >>> 9));
  assign dfi_cl    = clamp34(dfi_full);

  // Second multiply pass: gain compensation and both rates.
  logic                             k_done, sp_done, tr_done;
  logic signed [CLAMP_W+CORDIC_K_W-1:0] p_k;
  logic signed [CLAMP_W+15:0]       p_sp, p_tr;

  ddo_sermul #(.WA(CLAMP_W), .WB(CORDIC_K_W)) u_mul_k (
    .clk_i, .rst_ni, .start_i(m2_start), .a_i(ds_cl), .b_i(CORDIC_K),
    .done_o(k_done), .p_o(p_k)
  );

  ddo_sermul #(.WA(CLAMP_W), .WB(16)) u_mul_sp (
    .clk_i, .rst_ni, .start_i(m2_start), .a_i(ds_cl), .b_i(update_rate_q),
    .done_o(sp_done), .p_o(p_sp)
  );

  ddo_sermul #(.WA(CLAMP_W), .WB(16)) u_mul_tr (
    .clk_i, .rst_ni, .start_i(m2_start), .a_i(dfi_cl), .b_i(update_rate_q),
    .done_o(tr_done), .p_o(p_tr)
  );

  // Quadrant reduction of the midpoint heading.
  logic                      rot_start, flip;
  logic signed [CLAMP_W-1:0] kx, x0;
  logic [31:0]               ang;

  assign rot_start = (state_q == S_MUL2) && k_done;
  assign kx   = CLAMP_W'(p_k >>> 30);
  assign flip = mid_q[31] ^ mid_q[30];
  assign x0   = flip ? -kx : kx;
  assign ang  = flip ? {~mid_q[31], mid_q[30:0]} : mid_q;

  logic                    rot_done;
  logic signed [ROT_W-1:0] rot_x, rot_y;

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(rot_start), .x0_i(x0), .z0_i($signed(ang)),
    .done_o(rot_done), .x_o(rot_x), .y_o(rot_y)
  );

  // Sequencer and pose state.
  logic out_free;
  assign out_free = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pose_x_q <= START_X_RST;
      pose_y_q <= START_Y_RST;
      pose_h_q <= START_HEADING_RST;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.action) begin
              pose_x_q <= start_x_q;
              pose_y_q <= start_y_q;
              pose_h_q <= start_heading_q;
              state_q  <= S_OUT;
            end else begin
              state_q <= S_MUL1;
            end
          end
        end
        S_MUL1: if (ds_done) state_q <= S_MUL2;
        S_MUL2: if (k_done) state_q <= S_ROT;
        S_ROT: begin
          if (rot_done) begin
            pose_x_q <= sat32(64'($signed(pose_x_q)) + 64'(rot_x));
            pose_y_q <= sat32(64'($signed(pose_y_q)) + 64'(rot_y));
            pose_h_q <= pose_h_q + dfi_lo_q;
            state_q  <= S_OUT;
          end
        end
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Intermediate results held between passes.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      zero_rates_q <= in_i.action;
    end
    if (m2_start) begin
      mid_q    <= pose_h_q + half_full[31:0];
      dfi_lo_q <= dfi_full[31:0];
    end
    if (rot_start) begin
      speed_q <= sat32(64'(p_sp));
      turn_q  <= sat32(64'(p_tr));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_o.pos_x     <= pose_x_q;
      out_o.pos_y     <= pose_y_q;
      out_o.heading   <= pose_h_q;
      out_o.speed     <= zero_rates_q ? 32'h0 : speed_q;
      out_o.turn_rate <= zero_rates_q ? 32'h0 : turn_q;
    end
  end

  assign out_o.valid = ov_q;

  // Checks on the sequencer.
  a_restart_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.action |=> state_q == S_OUT)
    else $error("restart did not go straight to output");

  a_mul_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_done |-> fi_done && state_q == S_MUL1)
    else $error("first multiply pass out of step");

  a_rates_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_done |-> !sp_done && !tr_done && state_q == S_MUL2)
    else $error("rate products not finished before rotation");

  a_rot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_done |-> state_q == S_ROT)
    else $error("rotation finished outside its state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_free |=> ov_q && state_q == S_IDLE)
    else $error("result not presented");

endmodule

>>> tb/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 100ps

module tb_differential_drive_odometry;
  import ddo_pkg::*;

  localparam int unsigned IDLE_PCT   = 36;
  localparam int unsigned DRAIN_CYC  = 120;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_ITEMS = 100;

  // One pose update as it leaves the block.
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] speed;
    logic [31:0] turn_rate;
  } pose_update_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;

  // One row of the directed table: a tick or a register write.
  typedef struct {
    row_kind_e          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]        data;
    logic               action;
    logic [15:0]        right_count;
    logic [15:0]        left_count;
    logic               typed;
    pose_update_t       want;
  } tick_row_t;

  // Arctangent of 2^-i, binary-angle units, for the rotation steps used here.
  localparam longint ATAN_STEP [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ddo_in_if  tick_ch ();
  ddo_out_if pose_ch ();

  differential_drive_odometry uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_ch.sink),
    .out_o      (pose_ch.source)
  );

  // Predictor copy of the registers and the pose.
  logic [15:0] base_cnt;
  logic [23:0] dist_gain, head_gain;
  logic [15:0] tick_rate;
  logic [31:0] home_x, home_y, home_head;
  logic [31:0] cur_x, cur_y, cur_head;

  pose_update_t pose_expected_q [$];
  tick_row_t    tick_table [$];
  int unsigned  fail_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           idle_on;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint clamp_span(longint v);
    if (v > 64'sh1_0000_0000) return 64'sh1_0000_0000;
    if (v < -64'sh1_0000_0000) return -64'sh1_0000_0000;
    return v;
  endfunction

  function automatic logic [31:0] sat_word(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] scale_by_rate(longint v);
    if (tick_rate == 16'd0) return 32'd0;
    return sat_word(clamp_span(v) * longint'(tick_rate));
  endfunction

  // Computes the pose update caused by one tick and advances the pose.
  function automatic pose_update_t odometry_step(logic act, logic [15:0] rc, logic [15:0] lc);
    pose_update_t r;
    longint dr, dl, travel, dhead, half, xv, yv, zv, xs, ys;
    logic [31:0] ang;
    r.speed = 32'd0;
    r.turn_rate = 32'd0;
    if (act) begin
      cur_x = home_x;
      cur_y = home_y;
      cur_head = home_head;
    end else begin
      dr = longint'(rc) - longint'(base_cnt);
      dl = longint'(lc) - longint'(base_cnt);
      travel = ((dr + dl) * longint'(dist_gain)) >>> 9;
      dhead = ((dl - dr) * longint'(head_gain)) >>> 8;
      half = ((dl - dr) * longint'(head_gain)) >>> 9;
      ang = cur_head + half[31:0];
      // Rotate the gain-compensated distance onto the midpoint heading.
      xv = (clamp_span(travel) * longint'(CORDIC_K)) >>> 30;
      yv = 0;
      if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
        ang = ang - 32'h8000_0000;
        xv = -xv;
      end
      zv = longint'($signed(ang));
      for (int i = 0; i < 16; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (zv >= 0) begin
          xv = xv - ys; yv = yv + xs; zv = zv - ATAN_STEP[i];
        end else begin
          xv = xv + ys; yv = yv - xs; zv = zv + ATAN_STEP[i];
        end
      end
      cur_x = sat_word(longint'($signed(cur_x)) + xv);
      cur_y = sat_word(longint'($signed(cur_y)) + yv);
      cur_head = cur_head + dhead[31:0];
      r.speed = scale_by_rate(travel);
      r.turn_rate = scale_by_rate(dhead);
    end
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.heading = cur_head;
    return r;
  endfunction

  // Waits until every expected update is out and the block has settled.
  task automatic drain_block();
    while (pose_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Writes one register; the enable is dropped again before the next write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COUNT_BASE:    base_cnt  = data[15:0];
      REG_DISTANCE_GAIN: dist_gain = data[23:0];
      REG_HEADING_GAIN:  head_gain = data[23:0];
      REG_UPDATE_RATE:   tick_rate = data[15:0];
      REG_START_X:       home_x    = data;
      REG_START_Y:       home_y    = data;
      REG_START_HEADING: home_head = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sends one tick; the expectation is queued at the accepting edge.
  task automatic send_tick(logic act, logic [15:0] rc, logic [15:0] lc,
                           logic typed, pose_update_t want);
    pose_update_t pred;
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.action      <= act;
    tick_ch.right_count <= rc;
    tick_ch.left_count  <= lc;
    do @(posedge clk_i); while (!tick_ch.ready);
    pred = odometry_step(act, rc, lc);
    pose_expected_q.push_back(typed ? want : pred);
  endtask

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return base_cnt + 16'($signed($urandom_range(400)) - 200);
    if (r < 90) return 16'($urandom);
    return $urandom_range(1) ? 16'hFFFF : 16'h0000;
  endfunction

  // Checks each accepted update against the oldest expectation.
  always @(posedge clk_i) begin
    pose_update_t want;
    if (rst_ni) begin
      if ((tick_ch.valid && tick_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (pose_ch.valid && pose_ch.ready) begin
        if (pose_expected_q.size() == 0) begin
          $display("%0t: unexpected pose update x=%h", $realtime, pose_ch.pos_x);
          fail_count <= fail_count + 1;
        end else begin
          want = pose_expected_q.pop_front();
          if (want.pos_x !== pose_ch.pos_x || want.pos_y !== pose_ch.pos_y ||
              want.heading !== pose_ch.heading || want.speed !== pose_ch.speed ||
              want.turn_rate !== pose_ch.turn_rate) begin
            $display("%0t: mismatch expected x=%h y=%h hd=%h sp=%h tr=%h", $realtime,
                     want.pos_x, want.pos_y, want.heading, want.speed, want.turn_rate);
            $display("%0t:          actual   x=%h y=%h hd=%h sp=%h tr=%h", $realtime,
                     pose_ch.pos_x, pose_ch.pos_y, pose_ch.heading, pose_ch.speed,
                     pose_ch.turn_rate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pose_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // Ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** differential_drive_odometry: FAILED **");
      $finish;
    end
  end

  initial begin
    pose_update_t none;
    pose_update_t home;
    tick_row_t row;
    none = '0;
    home = '{32'd294912, 32'd294912, 32'h4000_0000, 32'd0, 32'd0};
    idle_on       = 1'b1;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_COUNT_BASE;
    cfg_data_i    = '0;
    tick_ch.valid = 1'b0;
    tick_ch.action = 1'b0;
    tick_ch.right_count = '0;
    tick_ch.left_count  = '0;
    pose_ch.ready = 1'b0;
    base_cnt  = COUNT_BASE_RST;
    dist_gain = DISTANCE_GAIN_RST;
    head_gain = HEADING_GAIN_RST;
    tick_rate = UPDATE_RATE_RST;
    home_x    = START_X_RST;
    home_y    = START_Y_RST;
    home_head = START_HEADING_RST;
    cur_x     = home_x;
    cur_y     = home_y;
    cur_head  = home_head;

    // Directed ticks and register writes: reset pose, count extremes, and the named special cases.
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b1, 16'h0000, 16'h0000, 1'b1, home});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h8000, 16'h8000, 1'b1, home});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h0000, 16'h0000, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h0000, 16'hFFFF, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'hFFFF, 16'h0000, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b1, 16'h1234, 16'h4321, 1'b1, home});
    tick_table.push_back('{ROW_REG, REG_UPDATE_RATE, 32'd0, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h8100, 16'h8400, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_UPDATE_RATE, 32'd65535, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h0000, 16'hFFFF, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_DISTANCE_GAIN, 32'hFFFFFF, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h0000, 16'h0000, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_HEADING_GAIN, 32'hFFFFFF, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'hFFFF, 16'h0000, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_COUNT_BASE, 32'd0, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_START_X, 32'h8000_0000, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_START_Y, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0, none});
    tick_table.push_back('{ROW_REG, REG_START_HEADING, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0,
                           none});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b1, 16'hFFFF, 16'h0000, 1'b1,
                           '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}});
    tick_table.push_back('{ROW_TICK, 0, 0, 1'b0, 16'h0001, 16'h0002, 1'b0, none});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tick_table[i]) begin
      row = tick_table[i];
      if (row.kind == ROW_REG) begin
        tick_ch.valid <= 1'b0;
        drain_block();
        write_reg(row.idx, row.data);
      end else begin
        send_tick(row.action, row.right_count, row.left_count, row.typed, row.want);
      end
    end
    tick_ch.valid <= 1'b0;

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      case (p)
        0: begin
          write_reg(REG_COUNT_BASE, COUNT_BASE_RST);
          write_reg(REG_DISTANCE_GAIN, DISTANCE_GAIN_RST);
          write_reg(REG_HEADING_GAIN, HEADING_GAIN_RST);
          write_reg(REG_UPDATE_RATE, UPDATE_RATE_RST);
          write_reg(REG_START_X, START_X_RST);
          write_reg(REG_START_Y, START_Y_RST);
          write_reg(REG_START_HEADING, START_HEADING_RST);
        end
        2: begin
          write_reg(REG_COUNT_BASE, 32'hFFFF);
          write_reg(REG_DISTANCE_GAIN, 32'hFFFFFF);
          write_reg(REG_HEADING_GAIN, 32'hFFFFFF);
          write_reg(REG_UPDATE_RATE, 32'hFFFF);
          write_reg(REG_START_X, 32'h7FFF_FFFF);
          write_reg(REG_START_Y, 32'h8000_0000);
          write_reg(REG_START_HEADING, 32'h0);
        end
        3: begin
          write_reg(REG_COUNT_BASE, 32'h0);
          write_reg(REG_DISTANCE_GAIN, 32'h0);
          write_reg(REG_HEADING_GAIN, 32'h0);
          write_reg(REG_UPDATE_RATE, 32'd1);
          write_reg(REG_START_X, 32'h0);
          write_reg(REG_START_Y, 32'h0);
          write_reg(REG_START_HEADING, 32'hC000_0000);
        end
        default: begin
          write_reg(REG_COUNT_BASE, $urandom_range(16'hFFFF));
          write_reg(REG_DISTANCE_GAIN, $urandom_range(1, 400000));
          write_reg(REG_HEADING_GAIN, $urandom_range(24'hFFFFFF));
          write_reg(REG_UPDATE_RATE, $urandom_range(1, 16'hFFFF));
          write_reg(REG_START_X, $urandom);
          write_reg(REG_START_Y, $urandom);
          write_reg(REG_START_HEADING, $urandom);
        end
      endcase
      // One phase runs with both sides streaming at full rate.
      idle_on = (p != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          tick_ch.valid <= 1'b0;
          while (pose_expected_q.size() != 0) @(posedge clk_i);
        end
        send_tick($urandom_range(15) == 0, pick_count(), pick_count(), 1'b0, none);
      end
      tick_ch.valid <= 1'b0;
    end
    idle_on = 1'b1;

    drain_block();
    if (fail_count == 0) begin
      $display("** differential_drive_odometry: PASSED **");
    end else begin
      $display("** differential_drive_odometry: FAILED **");
    end
    $finish;
  end

endmodule
